// File: design/idcr_pkg.sv
// Shared types and constants for the int8 dense channel requantize block.
package idcr_pkg;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_IN_ZP      = 2'd0;
  localparam logic [1:0] REG_OUT_ZP     = 2'd1;
  localparam logic [1:0] REG_RELU       = 2'd2;
  localparam logic [1:0] REG_CHAN_COUNT = 2'd3;

  // Fixed-point limits
  localparam logic [31:0] WORD_MIN_VAL = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX_VAL = 32'h7FFF_FFFF;
  localparam logic signed [33:0] BYTE_MIN_VAL = -34'sd128;
  localparam logic signed [33:0] BYTE_MAX_VAL = 34'sd127;

  // Rounding nudges for the doubling high multiply: +2^30 and 1 - 2^30
  localparam logic [63:0] NUDGE_POS = 64'h0000_0000_4000_0000;
  localparam logic [63:0] NUDGE_NEG = 64'hFFFF_FFFF_C000_0001;
  // Bias that turns the arithmetic shift into a divide toward zero
  localparam logic [63:0] TRUNC_BIAS = 64'h0000_0000_7FFF_FFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RND,
    S_HI,
    S_RSH,
    S_FIN
  } state_t;

  // Register file contents
  typedef struct packed {
    logic signed [7:0] in_zp;
    logic signed [7:0] out_zp;
    logic              relu;
    logic [10:0]       chan_count;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic mac_en;
    logic mul_en;
    logic rnd_en;
    logic hi_en;
    logic rsh_en;
    logic out_load;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } ctl_stat_t;

endpackage

// File: design/idcr_ctrl.sv
// Controller state machine: MAC streaming and the requantize step sequence.
module idcr_ctrl
  import idcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      last_term,
  input  ctl_stat_t stat,
  output logic      in_stall,
  output ctl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && last_term) state_next = S_MUL;
      end
      S_MUL: state_next = S_RND;
      S_RND: state_next = S_HI;
      S_HI:  state_next = S_RSH;
      S_RSH: state_next = S_FIN;
      S_FIN: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.mac_en = in_valid;
      end
      S_MUL: cmd.mul_en = 1'b1;
      S_RND: cmd.rnd_en = 1'b1;
      S_HI:  cmd.hi_en  = 1'b1;
      S_RSH: cmd.rsh_en = 1'b1;
      S_FIN: cmd.out_load = stat.out_free;
      default: in_stall = 1'b1;
    endcase
  end

endmodule

// File: design/idcr_dp.sv
// Datapath: accumulator, requantize stages, output register and channel counter.
module idcr_dp
  import idcr_pkg::*;
#(
  parameter int MAX_CHANNELS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  ctl_cmd_t           cmd,
  output ctl_stat_t          stat,
  input  logic signed [7:0]  act_value,
  input  logic signed [7:0]  weight_value,
  input  logic signed [31:0] bias_value,
  input  logic signed [31:0] multiplier,
  input  logic signed [5:0]  shift_amount,
  input  logic               last_term,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  out_value,
  output logic [9:0]         channel_index,
  output logic               last_channel
);

  localparam int IW = $clog2(MAX_CHANNELS);
  localparam int CW = IW + 1;

  // MAC
  logic signed [8:0]  act_d;
  logic signed [16:0] prod;
  logic [31:0]        acc_base;
  logic [31:0]        acc;
  logic               run_open;
  logic [31:0]        mult_r;
  logic [4:0]         left_r;
  logic [4:0]         right_r;
  logic [5:0]         neg_mag;

  assign act_d    = {act_value[7], act_value} - {cfg.in_zp[7], cfg.in_zp};
  assign prod     = act_d * weight_value;
  assign acc_base = run_open ? acc : bias_value;
  assign neg_mag  = 6'(-shift_amount);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open <= 1'b0;
    end else if (cmd.mac_en) begin
      run_open <= !last_term;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      acc <= acc_base + {{15{prod[16]}}, prod};
      if (last_term) begin
        mult_r <= multiplier;
        // positive shift is a left shift, otherwise right by the magnitude (max 31)
        if (!shift_amount[5] && shift_amount != 6'sd0) begin
          left_r  <= shift_amount[4:0];
          right_r <= 5'd0;
        end else begin
          left_r  <= 5'd0;
          right_r <= neg_mag[5] ? 5'd31 : neg_mag[4:0];
        end
      end
    end
  end

  // Left shift and 32x32 multiply
  logic [31:0]        xs;
  logic signed [63:0] ab;
  logic [63:0]        ab_r;
  logic               sat_r;

  assign xs = acc << left_r;
  assign ab = $signed(xs) * $signed(mult_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      ab_r  <= ab;
      sat_r <= (xs == WORD_MIN_VAL) && (mult_r == WORD_MIN_VAL);
    end
  end

  // Rounding nudge
  logic [63:0] t_r;

  always_ff @(posedge clk) begin
    if (cmd.rnd_en) begin
      t_r <= ab_r + (ab_r[63] ? NUDGE_NEG : NUDGE_POS);
    end
  end

  // Divide by 2^31 toward zero, saturate the one overflow case
  logic [63:0] adj;
  logic [31:0] h_r;

  assign adj = t_r + (t_r[63] ? TRUNC_BIAS : 64'h0);

  always_ff @(posedge clk) begin
    if (cmd.hi_en) begin
      h_r <= sat_r ? WORD_MAX_VAL : adj[62:31];
    end
  end

  // Rounding right shift: floor, then bump when remainder passes half
  logic [31:0] mask;
  logic [31:0] rem;
  logic [31:0] thr;
  logic [31:0] q;
  logic [31:0] q_r;
  logic        inc_r;

  assign mask = (32'h1 << right_r) - 32'h1;
  assign rem  = h_r & mask;
  assign thr  = (mask >> 1) + {31'b0, h_r[31]};
  assign q    = $signed(h_r) >>> right_r;

  always_ff @(posedge clk) begin
    if (cmd.rsh_en) begin
      q_r   <= q;
      inc_r <= rem > thr;
    end
  end

  // Zero point and clamp
  logic signed [33:0] val;
  logic signed [33:0] lo;
  logic signed [33:0] clamped;

  assign val = $signed({{2{q_r[31]}}, q_r}) + $signed({33'b0, inc_r})
             + $signed({{26{cfg.out_zp[7]}}, cfg.out_zp});
  assign lo  = cfg.relu ? $signed({{26{cfg.out_zp[7]}}, cfg.out_zp}) : BYTE_MIN_VAL;

  always_comb begin
    clamped = val;
    if (val < lo) clamped = lo;
    if (clamped > BYTE_MAX_VAL) clamped = BYTE_MAX_VAL;
  end

  // Channel counter against the effective channel count
  logic [IW-1:0] chan_cnt;
  logic [CW-1:0] eff;
  logic [CW-1:0] idx_ext;
  logic [CW-1:0] idx_inc;
  logic          over;
  logic          is_last;

  assign over    = (cfg.chan_count == 11'd0)
                || ({21'b0, cfg.chan_count} > 32'(MAX_CHANNELS));
  assign eff     = over ? CW'(MAX_CHANNELS) : CW'(cfg.chan_count);
  assign idx_ext = {1'b0, chan_cnt};
  assign idx_inc = idx_ext + CW'(1);
  assign is_last = idx_ext == (eff - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_cnt <= '0;
    end else if (cmd.out_load) begin
      chan_cnt <= (idx_inc >= eff) ? '0 : idx_inc[IW-1:0];
    end
  end

  // Output register
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value     <= clamped[7:0];
      channel_index <= 10'(chan_cnt);
      last_channel  <= is_last;
    end
  end

endmodule

// File: design/int8_dense_channel_requantize.sv
// Top level: int8 dense layer channel accumulate and requantize.
//
// Input channel: one (activation, weight) pair per transfer, in_valid/in_stall.
// The first pair of a channel loads bias_value; multiplier and shift_amount are
// sampled on the pair with last_term set. Pairs without last_term are taken one
// per cycle by a single 9x8 multiply-accumulate into a 32-bit accumulator.
// A last pair starts the requantize sequence (shift+32x32 multiply, nudge,
// divide by 2^31, rounding right shift, zero point and clamp), one step per
// cycle except where the final step waits on a held output register; in_stall
// is high through the whole sequence, and its final step loads the result into
// the output register. Output channel: out_valid/out_stall with out_value,
// channel_index and last_channel. While a result waits under out_stall, new
// pairs are still taken; only a second result waits in its final step.
// Reset (rst, synchronous) clears the sequencer, the open-channel flag, the
// channel counter and the output valid, and loads register defaults.
// Registers over APB at 0x0/0x4/0x8/0xC: input zero point, output zero point,
// ReLU enable, channel count; write only while the block is idle.
module int8_dense_channel_requantize
  import idcr_pkg::*;
#(
  parameter int MAX_CHANNELS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [7:0]  act_value,
  input  logic signed [7:0]  weight_value,
  input  logic signed [31:0] bias_value,
  input  logic signed [31:0] multiplier,
  input  logic signed [5:0]  shift_amount,
  input  logic               last_term,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  out_value,
  output logic [9:0]         channel_index,
  output logic               last_channel
);

  cfg_t      cfg;
  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  logic      cfg_wr;

  // Register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_zp      <= 8'sd0;
      cfg.out_zp     <= 8'sd0;
      cfg.relu       <= 1'b1;
      cfg.chan_count <= 11'd10;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_IN_ZP:      cfg.in_zp      <= pwdata[7:0];
        REG_OUT_ZP:     cfg.out_zp     <= pwdata[7:0];
        REG_RELU:       cfg.relu       <= pwdata[0];
        REG_CHAN_COUNT: cfg.chan_count <= pwdata[10:0];
        default:        cfg.relu       <= cfg.relu;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IN_ZP:      prdata = {24'b0, cfg.in_zp};
      REG_OUT_ZP:     prdata = {24'b0, cfg.out_zp};
      REG_RELU:       prdata = {31'b0, cfg.relu};
      REG_CHAN_COUNT: prdata = {21'b0, cfg.chan_count};
      default:        prdata = 32'b0;
    endcase
  end

  idcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_term (last_term),
    .stat      (stat),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  idcr_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .act_value     (act_value),
    .weight_value  (weight_value),
    .bias_value    (bias_value),
    .multiplier    (multiplier),
    .shift_amount  (shift_amount),
    .last_term     (last_term),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .channel_index (channel_index),
    .last_channel  (last_channel)
  );

`ifndef SYNTHESIS
  // A closing pair holds off input for the four fixed requantize steps
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_term |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
    else $error("input taken during requantize sequence");

  // A fresh result is loaded only as the sequencer returns to idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result loaded outside final step");
`endif

endmodule
